// File: design/dpd_pkg.sv
// shared types, constants and codes of the delta patch decoder
`default_nettype none

package dpd_pkg;

    // reference memory geometry and copy pointer width
    localparam int REF_AW    = 16;
    localparam int REF_DEPTH = 1 << REF_AW;
    localparam int PTR_W     = 18;
    localparam int SIZE_W    = 17;

    // item commands
    localparam logic [1:0] CMD_LOAD    = 2'd0;
    localparam logic [1:0] CMD_PATCH   = 2'd1;
    localparam logic [1:0] CMD_PUMP    = 2'd2;
    localparam logic [1:0] CMD_RESTART = 2'd3;

    // result error codes
    localparam logic [1:0] ERR_NONE   = 2'd0;
    localparam logic [1:0] ERR_SOURCE = 2'd1;
    localparam logic [1:0] ERR_BUSY   = 2'd2;

    // patch opcodes
    localparam logic [7:0] OP_LONG_COPY = 8'h00;
    localparam logic [7:0] OP_ESCAPE    = 8'h80;

    // patch parser phases
    typedef enum logic [2:0] {
        PH_IDLE,
        PH_LIT,
        PH_SHORT,
        PH_ESC,
        PH_MIDOFS,
        PH_BIGLIT,
        PH_LONG
    } dpd_phase_t;

    // one input word
    typedef struct packed {
        logic [1:0]        command;
        logic [7:0]        in_byte;
        logic [REF_AW-1:0] ref_address;
        logic              last_diff;
    } dpd_item_t;

    // one result word
    typedef struct packed {
        logic        out_valid;
        logic [7:0]  out_byte;
        logic [31:0] out_position;
        logic        copy_pending;
        logic        stream_done;
        logic [1:0]  error_code;
    } dpd_result_t;

    // reference memory request from the parser
    typedef struct packed {
        logic              wr_en;
        logic [REF_AW-1:0] wr_addr;
        logic [7:0]        wr_data;
        logic              rd_en;
        logic [REF_AW-1:0] rd_addr;
    } dpd_mem_req_t;

    // partial result that waits in the read stage for the memory read
    typedef struct packed {
        logic        out_valid;
        logic        from_mem;
        logic [7:0]  byte_val;
        logic [31:0] position;
        logic        copy_pending;
        logic        stream_done;
        logic [1:0]  error_code;
    } dpd_stage_t;

endpackage

`default_nettype wire

// File: design/delta_patch_decoder_core.sv
// top level of the delta patch decoder: reference ram, parser and result pipeline
`default_nettype none

// Rebuilds a byte block from a reference held in a 64 KiB byte ram and a
// stream of patch words. One word is taken per cycle while item_stall is low
// and each word gives exactly one result word; results pass through the read
// stage register, holding the registered ram read for copy bytes, and the
// output register. Load, patch, pump and restart words may follow each other in
// any mix at full rate; a load followed at once by a pump of the same
// address returns the new byte since the write lands before the read. The
// ram is not cleared: a copy from an address inside ref_size that was never
// loaded returns an unspecified byte. ref_size may be written only while
// the block holds no words in flight.
module delta_patch_decoder_core (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       item_valid,
    output logic                            item_stall,
    input  wire dpd_pkg::dpd_item_t         item,
    output logic                            result_valid,
    input  wire logic                       result_stall,
    output dpd_pkg::dpd_result_t            result,
    input  wire logic                       cfg_we,
    input  wire logic [dpd_pkg::SIZE_W-1:0] cfg_wdata
);

    logic [dpd_pkg::SIZE_W-1:0] ref_size_reg;
    dpd_pkg::dpd_mem_req_t      mem_req;
    dpd_pkg::dpd_stage_t        stage;
    dpd_pkg::dpd_stage_t        s1_reg;
    logic                       s1_valid_reg;
    dpd_pkg::dpd_result_t       out_reg, out_next;
    logic                       out_valid_reg;
    logic [7:0]                 rd_data;
    logic                       accept;
    logic                       out_free;
    logic                       s1_move;

    // flow control between the stages
    assign out_free   = !out_valid_reg || !result_stall;
    assign s1_move    = s1_valid_reg && out_free;
    assign item_stall = s1_valid_reg && !s1_move;
    assign accept     = item_valid && !item_stall;

    // configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ref_size_reg <= '0;
        end
        else if (cfg_we)
        begin
            ref_size_reg <= cfg_wdata;
        end
    end

    dpd_parser u_parser (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .item     (item),
        .ref_size (ref_size_reg),
        .mem_req  (mem_req),
        .stage    (stage)
    );

    dpd_ram #(
        .WIDTH (8),
        .DEPTH (dpd_pkg::REF_DEPTH)
    ) u_ref_ram (
        .clk     (clk),
        .wr_en   (mem_req.wr_en),
        .wr_addr (mem_req.wr_addr),
        .wr_data (mem_req.wr_data),
        .rd_en   (mem_req.rd_en),
        .rd_addr (mem_req.rd_addr),
        .rd_data (rd_data)
    );

    // read stage valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_move)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    // read stage payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_reg <= stage;
        end
    end

    // merge the ram byte into the result
    always_comb
    begin
        out_next.out_valid    = s1_reg.out_valid;
        out_next.out_byte     = s1_reg.from_mem ? rd_data : s1_reg.byte_val;
        out_next.out_position = s1_reg.position;
        out_next.copy_pending = s1_reg.copy_pending;
        out_next.stream_done  = s1_reg.stream_done;
        out_next.error_code   = s1_reg.error_code;
    end

    // output register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_move)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_free)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // output register payload
    always_ff @(posedge clk)
    begin
        if (s1_move)
        begin
            out_reg <= out_next;
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    // ram read data must hold while the read stage waits
    a_rd_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !s1_move |=> $stable(rd_data))
        else $error("reference read data changed under a waiting word");

    // bad copy source gives a zero byte that still counts as output
    a_src_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (result.error_code == dpd_pkg::ERR_SOURCE)
            |-> result.out_valid && (result.out_byte == 8'h00))
        else $error("source error without a zero output byte");

    // a dropped patch byte never emits output
    a_busy_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (result.error_code == dpd_pkg::ERR_BUSY)
            |-> !result.out_valid && result.copy_pending)
        else $error("patch word during copy emitted output");

endmodule

`default_nettype wire

// File: design/dpd_ram.sv
// generic single-clock ram, one write and one registered read port
`default_nettype none

module dpd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read port, data held until the next read
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// File: design/dpd_parser.sv
// patch parser and copy sequencer, issues reference memory accesses
`default_nettype none

module dpd_parser (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           accept,
    input  wire dpd_pkg::dpd_item_t             item,
    input  wire logic [dpd_pkg::SIZE_W-1:0]     ref_size,
    output dpd_pkg::dpd_mem_req_t               mem_req,
    output dpd_pkg::dpd_stage_t                 stage
);

    localparam logic [dpd_pkg::PTR_W-1:0] DEPTH_PTR = dpd_pkg::PTR_W'(dpd_pkg::REF_DEPTH);

    dpd_pkg::dpd_phase_t            phase_reg, phase_next;
    logic [2:0]                     op_index_reg, op_index_next;
    logic [31:0]                    op_bytes_reg, op_bytes_next;
    logic [dpd_pkg::PTR_W-1:0]      copy_base_reg, copy_base_next;
    logic [dpd_pkg::PTR_W-1:0]      copy_ptr_reg, copy_ptr_next;
    logic [15:0]                    copy_left_reg, copy_left_next;
    logic [23:0]                    lit_left_reg, lit_left_next;
    logic [31:0]                    out_count_reg, out_count_next;
    logic                           final_reg, final_next;

    logic [4:0]                     op_shift;
    logic [31:0]                    op_merged;
    logic [2:0]                     op_index_inc;
    logic                           start_copy;
    logic [dpd_pkg::PTR_W-1:0]      copy_delta;
    logic [15:0]                    copy_len;
    logic                           src_ok;
    logic [7:0]                     b;

    assign b            = item.in_byte;
    assign op_index_inc = op_index_reg + 3'd1;

    // operand byte placement for the multi-byte forms
    always_comb
    begin
        if (phase_reg == dpd_pkg::PH_MIDOFS)
        begin
            op_shift = op_index_reg[0] ? 5'd16 : 5'd8;
        end
        else
        begin
            op_shift = {op_index_reg[1:0], 3'b000};
        end
        op_merged = op_bytes_reg | ({24'b0, b} << op_shift);
    end

    // copy source must lie inside the loaded reference
    assign src_ok = (copy_ptr_reg < {1'b0, ref_size}) && (copy_ptr_reg < DEPTH_PTR);

    // next state and partial result of one word
    always_comb
    begin
        phase_next     = phase_reg;
        op_index_next  = op_index_reg;
        op_bytes_next  = op_bytes_reg;
        copy_base_next = copy_base_reg;
        copy_ptr_next  = copy_ptr_reg;
        copy_left_next = copy_left_reg;
        lit_left_next  = lit_left_reg;
        out_count_next = out_count_reg;
        final_next     = final_reg;
        start_copy     = 1'b0;
        copy_delta     = '0;
        copy_len       = '0;
        mem_req        = '0;
        stage          = '0;

        unique case (item.command)
            dpd_pkg::CMD_LOAD:
            begin
                mem_req.wr_en   = accept;
                mem_req.wr_addr = item.ref_address;
                mem_req.wr_data = b;
            end
            dpd_pkg::CMD_PATCH:
            begin
                if (copy_left_reg != 16'd0)
                begin
                    stage.error_code = dpd_pkg::ERR_BUSY;
                end
                else if (!final_reg)
                begin
                    unique case (phase_reg)
                        dpd_pkg::PH_LIT:
                        begin
                            lit_left_next  = lit_left_reg - 24'd1;
                            if (lit_left_next == 24'd0)
                            begin
                                phase_next = dpd_pkg::PH_IDLE;
                            end
                            stage.out_valid = 1'b1;
                            stage.byte_val  = b;
                        end
                        dpd_pkg::PH_SHORT:
                        begin
                            start_copy = 1'b1;
                            copy_delta = {{(dpd_pkg::PTR_W-8){b[7]}}, b};
                            copy_len   = {9'b0, op_bytes_reg[6:0]};
                        end
                        dpd_pkg::PH_ESC:
                        begin
                            op_index_next = 3'd0;
                            if (b == 8'h00)
                            begin
                                op_bytes_next = '0;
                                phase_next    = dpd_pkg::PH_BIGLIT;
                            end
                            else
                            begin
                                op_bytes_next = {24'b0, b};
                                phase_next    = dpd_pkg::PH_MIDOFS;
                            end
                        end
                        dpd_pkg::PH_MIDOFS:
                        begin
                            op_bytes_next = op_merged;
                            op_index_next = op_index_inc;
                            if (op_index_inc >= 3'd2)
                            begin
                                start_copy = 1'b1;
                                copy_delta = {{(dpd_pkg::PTR_W-16){op_merged[23]}},
                                              op_merged[23:8]};
                                copy_len   = {8'b0, op_merged[7:0]};
                            end
                        end
                        dpd_pkg::PH_BIGLIT:
                        begin
                            op_bytes_next = op_merged;
                            op_index_next = op_index_inc;
                            if (op_index_inc >= 3'd3)
                            begin
                                lit_left_next = op_merged[23:0];
                                phase_next    = (op_merged[23:0] != 24'd0) ?
                                                dpd_pkg::PH_LIT : dpd_pkg::PH_IDLE;
                            end
                        end
                        dpd_pkg::PH_LONG:
                        begin
                            op_bytes_next = op_merged;
                            op_index_next = op_index_inc;
                            if (op_index_inc >= 3'd4)
                            begin
                                start_copy = 1'b1;
                                copy_delta = {{(dpd_pkg::PTR_W-16){op_merged[31]}},
                                              op_merged[31:16]};
                                copy_len   = op_merged[15:0];
                            end
                        end
                        dpd_pkg::PH_IDLE:
                        begin
                            op_index_next = 3'd0;
                            op_bytes_next = '0;
                            priority if (b == dpd_pkg::OP_LONG_COPY)
                            begin
                                phase_next = dpd_pkg::PH_LONG;
                            end
                            else if (b < dpd_pkg::OP_ESCAPE)
                            begin
                                lit_left_next = {16'b0, b};
                                phase_next    = dpd_pkg::PH_LIT;
                            end
                            else if (b == dpd_pkg::OP_ESCAPE)
                            begin
                                phase_next = dpd_pkg::PH_ESC;
                            end
                            else
                            begin
                                op_bytes_next = {25'b0, b[6:0]};
                                phase_next    = dpd_pkg::PH_SHORT;
                            end
                        end
                        default:
                        begin
                            phase_next = dpd_pkg::PH_IDLE;
                        end
                    endcase
                    if (item.last_diff)
                    begin
                        final_next = 1'b1;
                    end
                end
            end
            dpd_pkg::CMD_PUMP:
            begin
                if (copy_left_reg != 16'd0)
                begin
                    stage.out_valid = 1'b1;
                    if (src_ok)
                    begin
                        stage.from_mem  = 1'b1;
                        mem_req.rd_en   = accept;
                        mem_req.rd_addr = copy_ptr_reg[dpd_pkg::REF_AW-1:0];
                    end
                    else
                    begin
                        stage.error_code = dpd_pkg::ERR_SOURCE;
                    end
                    copy_ptr_next  = copy_ptr_reg + dpd_pkg::PTR_W'(1);
                    copy_left_next = copy_left_reg - 16'd1;
                end
            end
            dpd_pkg::CMD_RESTART:
            begin
                phase_next     = dpd_pkg::PH_IDLE;
                op_index_next  = '0;
                op_bytes_next  = '0;
                copy_base_next = '0;
                copy_ptr_next  = '0;
                copy_left_next = '0;
                lit_left_next  = '0;
                out_count_next = '0;
                final_next     = 1'b0;
            end
            default:
            begin
                phase_next = phase_reg;
            end
        endcase

        // copy setup, offset taken from the end of the previous copy
        if (start_copy)
        begin
            copy_ptr_next  = copy_base_reg + copy_delta;
            copy_left_next = copy_len;
            copy_base_next = copy_ptr_next + {2'b0, copy_len};
            phase_next     = dpd_pkg::PH_IDLE;
        end

        // saturating output count
        if (stage.out_valid && (out_count_reg != 32'hFFFF_FFFF))
        begin
            out_count_next = out_count_reg + 32'd1;
        end

        stage.position     = out_count_next;
        stage.copy_pending = (copy_left_next != 16'd0);
        stage.stream_done  = final_next && (copy_left_next == 16'd0);
    end

    // parser and copy state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= dpd_pkg::PH_IDLE;
            op_index_reg  <= '0;
            op_bytes_reg  <= '0;
            copy_base_reg <= '0;
            copy_ptr_reg  <= '0;
            copy_left_reg <= '0;
            lit_left_reg  <= '0;
            out_count_reg <= '0;
            final_reg     <= 1'b0;
        end
        else if (accept)
        begin
            phase_reg     <= phase_next;
            op_index_reg  <= op_index_next;
            op_bytes_reg  <= op_bytes_next;
            copy_base_reg <= copy_base_next;
            copy_ptr_reg  <= copy_ptr_next;
            copy_left_reg <= copy_left_next;
            lit_left_reg  <= lit_left_next;
            out_count_reg <= out_count_next;
            final_reg     <= final_next;
        end
    end

endmodule

`default_nettype wire
